@@ rtl/core/hrpd_pkg.sv @@
// ----------------------------------------------------------------------------
// hrpd_pkg
// shared types and constants of the heart rate peak detector
// ----------------------------------------------------------------------------
package hrpd_pkg;

	// filter signal width, signed, and the serial mac geometry
	localparam int Y_W     = 34;
	localparam int ACC_W   = 52;
	localparam int RND_W   = ACC_W - 16;
	localparam int COEF_W  = 16;
	localparam int MCNT_W  = 5;

	// serial divider geometry
	localparam int DIV_N_W = 24;
	localparam int DIV_D_W = 16;
	localparam int DCNT_W  = 5;

	// q0.16 coefficients
	localparam logic [COEF_W-1:0] C_BASE_KEEP = 16'd63570;
	localparam logic [COEF_W-1:0] C_BASE_NEW  = 16'd1966;
	localparam logic [COEF_W-1:0] C_Y_NEW     = 16'd45875;
	localparam logic [COEF_W-1:0] C_Y_KEEP    = 16'd19661;
	localparam logic [COEF_W-1:0] C_ENV_KEEP  = 16'd62259;
	localparam logic [COEF_W-1:0] C_ENV_NEW   = 16'd3277;
	localparam logic [COEF_W-1:0] C_TH_HI     = 16'd42598;
	localparam logic [COEF_W-1:0] C_TH_LO     = 16'd19661;

	// 60000 ms per minute times 256 for q8.8
	localparam logic [DIV_N_W-1:0] RATE_NUM = 24'd15360000;

	// register map
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_PEAK_FLOOR  = 3'd0;
	localparam logic [2:0] REG_REARM_FLOOR = 3'd1;
	localparam logic [2:0] REG_MIN_IVL     = 3'd2;
	localparam logic [2:0] REG_MAX_IVL     = 3'd3;
	localparam logic [2:0] REG_JUMP        = 3'd4;
	localparam logic [2:0] REG_TIMEOUT     = 3'd5;

	localparam logic [17:0] RST_PEAK_FLOOR  = 18'd120;
	localparam logic [17:0] RST_REARM_FLOOR = 18'd60;
	localparam logic [15:0] RST_MIN_IVL     = 16'd350;
	localparam logic [15:0] RST_MAX_IVL     = 16'd1800;
	localparam logic [15:0] RST_JUMP        = 16'd6400;
	localparam logic [15:0] RST_TIMEOUT     = 16'd3000;

	typedef struct packed {
		logic [17:0] peak_floor;
		logic [17:0] rearm_floor;
		logic [15:0] min_ivl;
		logic [15:0] max_ivl;
		logic [15:0] jump;
		logic [15:0] timeout;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BASE_A,
		ST_BASE_B,
		ST_Y_A,
		ST_Y_B,
		ST_ENV_A,
		ST_ENV_B,
		ST_THI,
		ST_TLO,
		ST_DECIDE,
		ST_INST_DIV,
		ST_CHECK,
		ST_SUM,
		ST_AVG_DIV,
		ST_FINISH
	} state_t;

endpackage

@@ rtl/core/heart_rate_peak_detector_core.sv @@
// ----------------------------------------------------------------------------
// heart_rate_peak_detector_core
// ppg peak detector: dc tracker, smoother, envelope, peak gating, rate average
// ----------------------------------------------------------------------------
//
// channel  | handshake                  | word
// ---------+----------------------------+-------------------------------
// sample   | sample_valid/sample_ready  | ir_sample, now_ms
// result   | result_valid/result_ready  | heart_rate, beat_accepted
// config   | apb psel/penable/pready    | paddr, pwdata, prdata
//
// one word is worked at a time; every filter product runs through one
// bit-serial mac (load, a step per coefficient bit, done), eight
// products for each sample
// a sample that adds a beat also runs two serial divides, a check
// step and a history sweep
// a new sample is taken while the previous result waits in the output
// register; the sequencer only holds at its last step when that register
// is still full
// reset is asynchronous, active low; history storage needs no clearing
//
module heart_rate_peak_detector_core #(
	parameter int HISTORY_DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// sample channel
	input  logic                         sample_valid,
	output logic                         sample_ready,
	input  logic [17:0]                  ir_sample,
	input  logic [31:0]                  now_ms,
	// result channel
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [15:0]                  heart_rate,
	output logic                         beat_accepted,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hrpd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = 16 + FILL_W;
	localparam int Y_W    = hrpd_pkg::Y_W;
	localparam int RND_W  = hrpd_pkg::RND_W;
	localparam int N_W    = hrpd_pkg::DIV_N_W;

	hrpd_pkg::cfg_t cfg;

	hrpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hrpd_pkg::state_t state_q, state_d;

	// captured word
	logic [17:0] ir_q;
	logic [31:0] now_q;

	// filter state
	logic [31:0]           baseline_q;
	logic signed [Y_W-1:0] y_q;
	logic signed [Y_W-1:0] lf_q;
	logic signed [Y_W-1:0] of_q;
	logic [31:0]           env_q;
	logic [32:0]           th_hi_q;
	logic [32:0]           th_lo_q;

	// peak and rate state
	logic              armed_q;
	logic              seen_q;
	logic [31:0]       lpt_q;
	logic [15:0]       dt_q;
	logic [15:0]       inst_q;
	logic [15:0]       cur_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic [FILL_W-1:0] rd_idx_q;
	logic              pend_q;
	logic              beat_q;
	logic              step_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_rate_q;
	logic        out_beat_q;

	// history memory
	logic [15:0] hist_mem [HISTORY_DEPTH];
	logic [15:0] rd_data_q;
	logic        hist_we;

	// shared units
	logic                           mac_load, mac_clr, mac_busy;
	logic signed [Y_W-1:0]          mac_a;
	logic [hrpd_pkg::COEF_W-1:0]    mac_coef;
	logic signed [RND_W-1:0]        mac_rnd;
	logic                           div_load, div_busy;
	logic [N_W-1:0]                 div_num;
	logic [hrpd_pkg::DIV_D_W-1:0]   div_den;
	logic [N_W-1:0]                 div_quot;

	hrpd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (mac_load),
		.clr    (mac_clr),
		.a      (mac_a),
		.coef   (mac_coef),
		.busy   (mac_busy),
		.rnd    (mac_rnd)
	);

	hrpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// derived values
	logic signed [Y_W-1:0] s_ext, base_ext, env_ext, x_val, y_abs;
	logic [32:0]           rnd_th, peak_fl, rearm_fl;
	logic [31:0]           env_sat, dt_full, since_peak;
	logic                  peak, in_range, unit_done, mac_state, div_state;
	logic [15:0]           inst_sat, diff;
	logic                  take_rate, sum_done, leave, rearm, timed_out;

	assign s_ext    = $signed({2'b00, ir_q, 14'd0});
	assign base_ext = $signed({2'b00, baseline_q});
	assign env_ext  = $signed({2'b00, env_q});
	assign x_val    = s_ext - base_ext;
	assign y_abs    = y_q[Y_W-1] ? -y_q : y_q;

	// envelope saturates to 32 bits; thresholds never go below their floors
	assign env_sat  = (mac_rnd[RND_W-1:32] != '0) ? 32'hFFFF_FFFF : mac_rnd[31:0];
	assign rnd_th   = mac_rnd[32:0];
	assign peak_fl  = {1'b0, cfg.peak_floor, 14'd0};
	assign rearm_fl = {1'b0, cfg.rearm_floor, 14'd0};

	// local maximum of the smoothed signal above the high threshold
	assign peak = (lf_q > of_q) && (lf_q > y_q) &&
		($signed({lf_q[Y_W-1], lf_q}) > $signed({2'b00, th_hi_q}));

	assign dt_full  = now_q - lpt_q;
	assign in_range = seen_q && (dt_full > {16'd0, cfg.min_ivl}) &&
		(dt_full < {16'd0, cfg.max_ivl});

	assign inst_sat  = (div_quot[N_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
	assign diff      = (inst_q > cur_q) ? (inst_q - cur_q) : (cur_q - inst_q);
	assign take_rate = (cur_q == 16'd0) || (diff < cfg.jump);
	assign sum_done  = (rd_idx_q == fill_q) && !pend_q;

	assign mac_state = (state_q == hrpd_pkg::ST_BASE_A) || (state_q == hrpd_pkg::ST_BASE_B) ||
		(state_q == hrpd_pkg::ST_Y_A) || (state_q == hrpd_pkg::ST_Y_B) ||
		(state_q == hrpd_pkg::ST_ENV_A) || (state_q == hrpd_pkg::ST_ENV_B) ||
		(state_q == hrpd_pkg::ST_THI) || (state_q == hrpd_pkg::ST_TLO);
	assign div_state = (state_q == hrpd_pkg::ST_INST_DIV) || (state_q == hrpd_pkg::ST_AVG_DIV);
	assign unit_done = step_q && (mac_state ? !mac_busy : !div_busy);

	// rearm and timeout see the peak bookkeeping done earlier in the word
	assign leave      = (state_q == hrpd_pkg::ST_FINISH) && (!out_valid_q || result_ready);
	assign rearm      = !armed_q && (y_q < $signed({1'b0, th_lo_q}));
	assign since_peak = now_q - lpt_q;
	assign timed_out  = seen_q && (since_peak > {16'd0, cfg.timeout});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hrpd_pkg::ST_IDLE:     if (sample_valid) state_d = hrpd_pkg::ST_BASE_A;
			hrpd_pkg::ST_BASE_A:   if (unit_done) state_d = hrpd_pkg::ST_BASE_B;
			hrpd_pkg::ST_BASE_B:   if (unit_done) state_d = hrpd_pkg::ST_Y_A;
			hrpd_pkg::ST_Y_A:      if (unit_done) state_d = hrpd_pkg::ST_Y_B;
			hrpd_pkg::ST_Y_B:      if (unit_done) state_d = hrpd_pkg::ST_ENV_A;
			hrpd_pkg::ST_ENV_A:    if (unit_done) state_d = hrpd_pkg::ST_ENV_B;
			hrpd_pkg::ST_ENV_B:    if (unit_done) state_d = hrpd_pkg::ST_THI;
			hrpd_pkg::ST_THI:      if (unit_done) state_d = hrpd_pkg::ST_TLO;
			hrpd_pkg::ST_TLO:      if (unit_done) state_d = hrpd_pkg::ST_DECIDE;
			hrpd_pkg::ST_DECIDE: begin
				if (armed_q && peak && in_range) begin
					state_d = hrpd_pkg::ST_INST_DIV;
				end else begin
					state_d = hrpd_pkg::ST_FINISH;
				end
			end
			hrpd_pkg::ST_INST_DIV: if (unit_done) state_d = hrpd_pkg::ST_CHECK;
			hrpd_pkg::ST_CHECK: begin
				state_d = take_rate ? hrpd_pkg::ST_SUM : hrpd_pkg::ST_FINISH;
			end
			hrpd_pkg::ST_SUM:      if (sum_done) state_d = hrpd_pkg::ST_AVG_DIV;
			hrpd_pkg::ST_AVG_DIV:  if (unit_done) state_d = hrpd_pkg::ST_FINISH;
			hrpd_pkg::ST_FINISH:   if (leave) state_d = hrpd_pkg::ST_IDLE;
			default:               state_d = hrpd_pkg::ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mac_load = 1'b0;
		mac_clr  = 1'b0;
		mac_a    = '0;
		mac_coef = '0;
		div_load = 1'b0;
		div_num  = '0;
		div_den  = '0;
		hist_we  = 1'b0;
		case (state_q)
			hrpd_pkg::ST_BASE_A: begin
				mac_clr = 1'b1; mac_a = base_ext; mac_coef = hrpd_pkg::C_BASE_KEEP;
			end
			hrpd_pkg::ST_BASE_B: begin
				mac_a = s_ext; mac_coef = hrpd_pkg::C_BASE_NEW;
			end
			hrpd_pkg::ST_Y_A: begin
				mac_clr = 1'b1; mac_a = x_val; mac_coef = hrpd_pkg::C_Y_NEW;
			end
			hrpd_pkg::ST_Y_B: begin
				mac_a = lf_q; mac_coef = hrpd_pkg::C_Y_KEEP;
			end
			hrpd_pkg::ST_ENV_A: begin
				mac_clr = 1'b1; mac_a = env_ext; mac_coef = hrpd_pkg::C_ENV_KEEP;
			end
			hrpd_pkg::ST_ENV_B: begin
				mac_a = y_abs; mac_coef = hrpd_pkg::C_ENV_NEW;
			end
			hrpd_pkg::ST_THI: begin
				mac_clr = 1'b1; mac_a = env_ext; mac_coef = hrpd_pkg::C_TH_HI;
			end
			hrpd_pkg::ST_TLO: begin
				mac_clr = 1'b1; mac_a = env_ext; mac_coef = hrpd_pkg::C_TH_LO;
			end
			hrpd_pkg::ST_INST_DIV: begin
				div_num = hrpd_pkg::RATE_NUM + N_W'(dt_q >> 1);
				div_den = dt_q;
			end
			hrpd_pkg::ST_CHECK: begin
				hist_we = take_rate;
			end
			hrpd_pkg::ST_AVG_DIV: begin
				div_num = N_W'(sum_q) + N_W'(fill_q >> 1);
				div_den = hrpd_pkg::DIV_D_W'(fill_q);
			end
			default: ;
		endcase
		if (mac_state) begin
			mac_load = !step_q;
		end
		if (div_state) begin
			div_load = !step_q;
		end
	end

	assign sample_ready  = (state_q == hrpd_pkg::ST_IDLE);
	assign result_valid  = out_valid_q;
	assign heart_rate    = out_rate_q;
	assign beat_accepted = out_beat_q;

	// history memory, registered read
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[slot_q] <= inst_q;
		end
		rd_data_q <= hist_mem[rd_idx_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hrpd_pkg::ST_IDLE;
			step_q      <= 1'b0;
			ir_q        <= '0;
			now_q       <= '0;
			baseline_q  <= '0;
			y_q         <= '0;
			lf_q        <= '0;
			of_q        <= '0;
			env_q       <= '0;
			th_hi_q     <= '0;
			th_lo_q     <= '0;
			armed_q     <= 1'b1;
			seen_q      <= 1'b0;
			lpt_q       <= '0;
			dt_q        <= '0;
			inst_q      <= '0;
			cur_q       <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			beat_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_rate_q  <= '0;
			out_beat_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// issue flag for the shared units
			if (mac_state || div_state) begin
				if (!step_q) begin
					step_q <= 1'b1;
				end else if (unit_done) begin
					step_q <= 1'b0;
				end
			end else begin
				step_q <= 1'b0;
			end

			// a word handed over this cycle without a new one behind it
			if (out_valid_q && result_ready && !leave) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				hrpd_pkg::ST_IDLE: begin
					if (sample_valid) begin
						ir_q   <= ir_sample;
						now_q  <= now_ms;
						beat_q <= 1'b0;
					end
				end
				hrpd_pkg::ST_BASE_B: if (unit_done) baseline_q <= mac_rnd[31:0];
				hrpd_pkg::ST_Y_B:    if (unit_done) y_q <= mac_rnd[Y_W-1:0];
				hrpd_pkg::ST_ENV_B:  if (unit_done) env_q <= env_sat;
				hrpd_pkg::ST_THI: begin
					if (unit_done) th_hi_q <= (rnd_th < peak_fl) ? peak_fl : rnd_th;
				end
				hrpd_pkg::ST_TLO: begin
					if (unit_done) th_lo_q <= (rnd_th < rearm_fl) ? rearm_fl : rnd_th;
				end
				hrpd_pkg::ST_DECIDE: begin
					dt_q <= dt_full[15:0];
					if (armed_q && peak) begin
						lpt_q   <= now_q;
						seen_q  <= 1'b1;
						armed_q <= 1'b0;
					end
				end
				hrpd_pkg::ST_INST_DIV: if (unit_done) inst_q <= inst_sat;
				hrpd_pkg::ST_CHECK: begin
					if (take_rate) begin
						slot_q   <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 :
							slot_q + 1'b1;
						if (fill_q < FILL_W'(HISTORY_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						sum_q    <= '0;
						rd_idx_q <= '0;
						pend_q   <= 1'b0;
						beat_q   <= 1'b1;
					end
				end
				hrpd_pkg::ST_SUM: begin
					// one history entry per cycle, the data in the cycle after its address
					if (rd_idx_q != fill_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						pend_q   <= 1'b1;
					end else begin
						pend_q   <= 1'b0;
					end
					if (pend_q) begin
						sum_q <= sum_q + SUM_W'(rd_data_q);
					end
				end
				hrpd_pkg::ST_AVG_DIV: if (unit_done) cur_q <= div_quot[15:0];
				hrpd_pkg::ST_FINISH: begin
					if (leave) begin
						if (rearm) begin
							armed_q <= 1'b1;
						end
						if (timed_out) begin
							cur_q <= '0;
						end
						of_q        <= lf_q;
						lf_q        <= y_q;
						out_valid_q <= 1'b1;
						out_rate_q  <= timed_out ? 16'd0 : cur_q;
						out_beat_q  <= beat_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/hrpd_mac.sv @@
// ----------------------------------------------------------------------------
// hrpd_mac
// bit-serial multiply-accumulate, one coefficient bit per cycle, rounded
// ----------------------------------------------------------------------------
module hrpd_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic                               clr,
	input  logic signed [hrpd_pkg::Y_W-1:0]    a,
	input  logic        [hrpd_pkg::COEF_W-1:0] coef,
	output logic                               busy,
	output logic signed [hrpd_pkg::RND_W-1:0]  rnd
);

	logic signed [hrpd_pkg::ACC_W-1:0]  acc_q;
	logic signed [hrpd_pkg::ACC_W-1:0]  a_q;
	logic        [hrpd_pkg::COEF_W-1:0] coef_q;
	logic        [hrpd_pkg::MCNT_W-1:0] cnt_q;
	logic signed [hrpd_pkg::ACC_W-1:0]  biased;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			a_q    <= '0;
			coef_q <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			if (clr) begin
				acc_q <= '0;
			end
			a_q    <= hrpd_pkg::ACC_W'(a);
			coef_q <= coef;
			cnt_q  <= hrpd_pkg::MCNT_W'(hrpd_pkg::COEF_W);
		end else if (cnt_q != '0) begin
			if (coef_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q    <= a_q <<< 1;
			coef_q <= coef_q >> 1;
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	// round half up then drop the 16 fraction bits
	assign biased = acc_q + hrpd_pkg::ACC_W'(32768);
	assign rnd    = biased[hrpd_pkg::ACC_W-1:16];
	assign busy   = (cnt_q != '0);

endmodule

@@ rtl/core/hrpd_div.sv @@
// ----------------------------------------------------------------------------
// hrpd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hrpd_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [hrpd_pkg::DIV_N_W-1:0]        num,
	input  logic [hrpd_pkg::DIV_D_W-1:0]        den,
	output logic                                busy,
	output logic [hrpd_pkg::DIV_N_W-1:0]        quot
);

	logic [hrpd_pkg::DIV_N_W-1:0] num_q;
	logic [hrpd_pkg::DIV_D_W-1:0] den_q;
	logic [hrpd_pkg::DIV_D_W-1:0] rem_q;
	logic [hrpd_pkg::DCNT_W-1:0]  cnt_q;
	logic [hrpd_pkg::DIV_D_W:0]   trial;
	logic                         fits;

	assign trial = {rem_q, num_q[hrpd_pkg::DIV_N_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (load) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			cnt_q <= hrpd_pkg::DCNT_W'(hrpd_pkg::DIV_N_W);
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= hrpd_pkg::DIV_D_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[hrpd_pkg::DIV_D_W-1:0];
			end
			num_q <= {num_q[hrpd_pkg::DIV_N_W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = num_q;

endmodule

@@ rtl/core/hrpd_regs.sv @@
// ----------------------------------------------------------------------------
// hrpd_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module hrpd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hrpd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output hrpd_pkg::cfg_t               cfg
);

	hrpd_pkg::cfg_t cfg_q;
	logic           wr;

	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_floor  <= hrpd_pkg::RST_PEAK_FLOOR;
			cfg_q.rearm_floor <= hrpd_pkg::RST_REARM_FLOOR;
			cfg_q.min_ivl     <= hrpd_pkg::RST_MIN_IVL;
			cfg_q.max_ivl     <= hrpd_pkg::RST_MAX_IVL;
			cfg_q.jump        <= hrpd_pkg::RST_JUMP;
			cfg_q.timeout     <= hrpd_pkg::RST_TIMEOUT;
		end else if (wr) begin
			case (paddr[4:2])
				hrpd_pkg::REG_PEAK_FLOOR:  cfg_q.peak_floor  <= pwdata[17:0];
				hrpd_pkg::REG_REARM_FLOOR: cfg_q.rearm_floor <= pwdata[17:0];
				hrpd_pkg::REG_MIN_IVL:     cfg_q.min_ivl     <= pwdata[15:0];
				hrpd_pkg::REG_MAX_IVL:     cfg_q.max_ivl     <= pwdata[15:0];
				hrpd_pkg::REG_JUMP:        cfg_q.jump        <= pwdata[15:0];
				hrpd_pkg::REG_TIMEOUT:     cfg_q.timeout     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			hrpd_pkg::REG_PEAK_FLOOR:  prdata = {14'd0, cfg_q.peak_floor};
			hrpd_pkg::REG_REARM_FLOOR: prdata = {14'd0, cfg_q.rearm_floor};
			hrpd_pkg::REG_MIN_IVL:     prdata = {16'd0, cfg_q.min_ivl};
			hrpd_pkg::REG_MAX_IVL:     prdata = {16'd0, cfg_q.max_ivl};
			hrpd_pkg::REG_JUMP:        prdata = {16'd0, cfg_q.jump};
			hrpd_pkg::REG_TIMEOUT:     prdata = {16'd0, cfg_q.timeout};
			default:                   prdata = '0;
		endcase
	end

endmodule
